// File: design/upmt_pkg.sv
// Package for the unique pair map table: sizes, command and status codes,
// and the structs passed between the scan engine and the top level.
// No dependencies.
`timescale 1ns / 1ps

package upmt_pkg;

  // Table size and key width.
  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 16;

  // Fixed widths of the item fields.
  localparam int FIELD_W  = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OCNT_W   = 7;

  // Derived widths for addresses and the fill count.
  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Insert status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP_LEFT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP_RIGHT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef logic [KEY_BITS-1:0] key_t;

  // Result of one item, handed from the engine to the output register.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    key_t                partner;
    logic [CNT_W-1:0]    count;
  } res_t;

  // Access to the two key memories.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    key_t              wleft;
    key_t              wright;
  } mem_req_t;

endpackage

// File: design/upmt_ram.sv
// Generic single-clock RAM: one write port and one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module upmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/upmt_engine.sv
// Scan engine of the pair table: takes one item, walks the stored pairs
// one per cycle through the key memories and appends on a clean insert.
// Depends on upmt_pkg.
`timescale 1ns / 1ps

module upmt_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [upmt_pkg::CMD_W-1:0]      in_cmd,
  input  logic                            in_side,
  input  logic [upmt_pkg::FIELD_W-1:0]    in_key_left,
  input  logic [upmt_pkg::FIELD_W-1:0]    in_key_right,
  input  logic [upmt_pkg::FIELD_W-1:0]    in_query_key,
  output upmt_pkg::mem_req_t              mem_req,
  input  upmt_pkg::key_t                  rd_left,
  input  upmt_pkg::key_t                  rd_right,
  output logic                            res_valid,
  output upmt_pkg::res_t                  res,
  input  logic                            res_take
);
  import upmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic                side_r;
  key_t                kl_r, kr_r, qk_r;
  res_t                res_r, res_nxt;

  logic                accept;
  logic                issue;
  logic                hit_left, hit_right, hit_find;
  logic                scan_end;

  assign accept = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Compare the entry whose read data arrives this cycle.
  assign hit_left  = pend_r && (rd_left == kl_r);
  assign hit_right = pend_r && (rd_right == kr_r);
  assign hit_find  = pend_r && ((side_r ? rd_right : rd_left) == qk_r);

  // Next read while entries remain below the fill count.
  assign issue = (state_r == S_SCAN) && (idx_r < count_r);

  // All entries checked without a hit, or the table was empty.
  assign scan_end = (idx_r == count_r) && !pend_r;

  // Latch the item fields at acceptance; keys keep their low KEY_BITS bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      side_r <= in_side;
      kl_r   <= in_key_left[KEY_BITS-1:0];
      kr_r   <= in_key_right[KEY_BITS-1:0];
      qk_r   <= in_query_key[KEY_BITS-1:0];
    end
  end

  // Sequencer: accept, scan, hold the result until the output side takes it.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    res_nxt   = res_r;
    mem_req   = '0;
    mem_req.raddr  = idx_r[ADDR_W-1:0];
    mem_req.waddr  = count_r[ADDR_W-1:0];
    mem_req.wleft  = kl_r;
    mem_req.wright = kr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          res_nxt = '0;
          if (in_cmd == CMD_INSERT || in_cmd == CMD_FIND) begin
            state_nxt = S_SCAN;
          end else begin
            if (in_cmd == CMD_CLEAR) begin
              count_nxt = '0;
            end
            res_nxt.count = count_nxt;
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        mem_req.rd_en = issue;
        pend_nxt      = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        res_nxt.count = count_r;
        if (cmd_r == CMD_INSERT) begin
          priority if (hit_left) begin
            res_nxt.status = ST_DUP_LEFT;
            pend_nxt = 1'b0;
            state_nxt = S_DONE;
          end else if (hit_right) begin
            res_nxt.status = ST_DUP_RIGHT;
            pend_nxt = 1'b0;
            state_nxt = S_DONE;
          end else if (scan_end || (pend_r && idx_r == count_r)) begin
            pend_nxt = 1'b0;
            state_nxt = S_DONE;
            if (count_r == FULL_CNT) begin
              res_nxt.status = ST_FULL;
            end else begin
              // Append the new pair at the end of the table.
              mem_req.wr_en  = 1'b1;
              count_nxt      = count_r + 1'b1;
              res_nxt.status = ST_OK;
              res_nxt.count  = count_nxt;
            end
          end else begin
            res_nxt.status = ST_OK;
          end
        end else begin
          priority if (hit_find) begin
            res_nxt.found   = 1'b1;
            res_nxt.partner = side_r ? rd_left : rd_right;
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (scan_end || (pend_r && idx_r == count_r)) begin
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else begin
            res_nxt.found = 1'b0;
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// File: design/unique_pair_map_table.sv
// Top level of the unique pair map table: key memories, scan engine and
// the output register. Depends on upmt_pkg, upmt_ram and upmt_engine.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  cmd, side, key_left, key_right, query_key
//   out_     output     out_valid/out_stall status, found, partner, entry_count
//
// An insert or find reads the stored pairs through the read port of the key
// memories, one entry per cycle, and no new item is taken until its result moves
// to the output register; a hit ends the scan early. Clear and the unused command
// do not scan. Reset empties the table; memory contents are never cleared, since
// only entries below the fill count are read. While a result waits in the output
// register the next item is still taken.
`timescale 1ns / 1ps

module unique_pair_map_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [upmt_pkg::CMD_W-1:0]        in_cmd,
  input  logic                              in_side,
  input  logic [upmt_pkg::FIELD_W-1:0]      in_key_left,
  input  logic [upmt_pkg::FIELD_W-1:0]      in_key_right,
  input  logic [upmt_pkg::FIELD_W-1:0]      in_query_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [upmt_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_found,
  output logic [upmt_pkg::FIELD_W-1:0]      out_partner,
  output logic [upmt_pkg::OCNT_W-1:0]       out_entry_count
);
  import upmt_pkg::*;

  mem_req_t mem_req;
  key_t     rd_left, rd_right;
  logic     res_valid, res_take;
  res_t     res;
  logic     out_valid_r;
  res_t     out_r;

  // Left and right key memories.
  upmt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_left_ram (
    .clk   (clk),
    .we    (mem_req.wr_en),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wleft),
    .re    (mem_req.rd_en),
    .raddr (mem_req.raddr),
    .rdata (rd_left)
  );

  upmt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_right_ram (
    .clk   (clk),
    .we    (mem_req.wr_en),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wright),
    .re    (mem_req.rd_en),
    .raddr (mem_req.raddr),
    .rdata (rd_right)
  );

  upmt_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_side      (in_side),
    .in_key_left  (in_key_left),
    .in_key_right (in_key_right),
    .in_query_key (in_query_key),
    .mem_req      (mem_req),
    .rd_left      (rd_left),
    .rd_right     (rd_right),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // The output register loads when it is empty or being emptied.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_found       = out_r.found;
  assign out_partner     = FIELD_W'(out_r.partner);
  assign out_entry_count = OCNT_W'(out_r.count);

endmodule

// File: tb/tb_unique_pair_map_table.sv
// Self-checking testbench for the unique pair map table: a queued driver, a
// result monitor and a pair-table predictor that tracks every accepted item.
// Depends on upmt_pkg and unique_pair_map_table.
`timescale 1ns / 1ps

module tb_unique_pair_map_table;
  import upmt_pkg::*;

  // Command 3 is not decoded by the block and must leave the table alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TARGET_ITEMS   = 850;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 200;

  // One input item plus a flag that makes the driver wait for all results.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               side;
    logic [FIELD_W-1:0] key_left;
    logic [FIELD_W-1:0] key_right;
    logic [FIELD_W-1:0] query_key;
    logic               drain;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [FIELD_W-1:0]  partner;
    logic [OCNT_W-1:0]   entry_count;
  } table_reply_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = CMD_CLEAR;
  logic in_side = 1'b0;
  logic [FIELD_W-1:0] in_key_left = '0;
  logic [FIELD_W-1:0] in_key_right = '0;
  logic [FIELD_W-1:0] in_query_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic out_found;
  logic [FIELD_W-1:0] out_partner;
  logic [OCNT_W-1:0] out_entry_count;

  // Predicted contents of the pair table.
  key_t table_left [ENTRIES];
  key_t table_right[ENTRIES];
  int   table_fill = 0;

  table_op_t    pending_ops[$];
  table_reply_t awaited_replies[$];
  table_op_t    offered_op;
  bit           drain_next = 1'b0;

  int ops_total = 0;
  int ops_accepted = 0;
  int replies_seen = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int send_burst = 0;
  int recv_stall = 0;
  int recv_burst = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  unique_pair_map_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_side        (in_side),
    .in_key_left    (in_key_left),
    .in_key_right   (in_key_right),
    .in_query_key   (in_query_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_partner    (out_partner),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one item to the predicted table and returns the result it causes.
  function automatic table_reply_t apply_to_table(table_op_t op);
    table_reply_t r;
    key_t kl;
    key_t kr;
    key_t qk;
    int   idx;
    bit   hit;
    r   = '0;
    kl  = key_t'(op.key_left);
    kr  = key_t'(op.key_right);
    qk  = key_t'(op.query_key);
    hit = 1'b0;
    case (op.cmd)
      CMD_INSERT: begin
        // The first stored pair in insertion order decides the duplicate kind.
        for (idx = 0; idx < table_fill && !hit; idx++) begin
          if (table_left[idx] == kl) begin
            r.status = ST_DUP_LEFT;
            hit = 1'b1;
          end else if (table_right[idx] == kr) begin
            r.status = ST_DUP_RIGHT;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (table_fill >= ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            table_left[table_fill]  = kl;
            table_right[table_fill] = kr;
            table_fill++;
            r.status = ST_OK;
          end
        end
      end
      CMD_FIND: begin
        for (idx = 0; idx < table_fill && !hit; idx++) begin
          if ((op.side ? table_right[idx] : table_left[idx]) == qk) begin
            r.found   = 1'b1;
            r.partner = FIELD_W'(op.side ? table_left[idx] : table_right[idx]);
            hit = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        table_fill = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = OCNT_W'(table_fill);
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_key();
    return FIELD_W'($urandom());
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_op(input logic [CMD_W-1:0] cmd, input logic side,
                        input logic [FIELD_W-1:0] kl, input logic [FIELD_W-1:0] kr,
                        input logic [FIELD_W-1:0] qk);
    table_op_t op;
    op.cmd       = cmd;
    op.side      = side;
    op.key_left  = kl;
    op.key_right = kr;
    op.query_key = qk;
    op.drain     = drain_next;
    drain_next   = 1'b0;
    pending_ops.push_back(op);
  endtask

  // Fills the table to the last entry, then probes it while full.
  task automatic gen_fill_episode();
    logic [FIELD_W-1:0] bl;
    logic [FIELD_W-1:0] br;
    int i;
    int j;
    bl = rand_key();
    br = rand_key();
    add_op(CMD_CLEAR, 1'($urandom_range(0, 1)), rand_key(), rand_key(), rand_key());
    for (i = 0; i < ENTRIES; i++) begin
      add_op(CMD_INSERT, 1'($urandom_range(0, 1)), bl + FIELD_W'(i), br + FIELD_W'(i * 7),
             rand_key());
    end
    for (i = 0; i < 3; i++) begin
      j = $urandom_range(0, ENTRIES - 1);
      add_op(CMD_INSERT, 1'b0, bl + FIELD_W'(100 + i), br + FIELD_W'(1000 + i), rand_key());
      add_op(CMD_INSERT, 1'b0, bl + FIELD_W'(j), br + FIELD_W'(2000 + i), rand_key());
      add_op(CMD_INSERT, 1'b1, bl + FIELD_W'(300 + i), br + FIELD_W'(j * 7), rand_key());
      add_op(CMD_FIND, 1'b0, rand_key(), rand_key(), bl + FIELD_W'(j));
      add_op(CMD_FIND, 1'b1, rand_key(), rand_key(), br + FIELD_W'(j * 7));
    end
    add_op(CMD_FIND, 1'b0, rand_key(), rand_key(), bl + FIELD_W'(ENTRIES - 1));
    add_op(CMD_FIND, 1'b1, rand_key(), rand_key(), br + FIELD_W'((ENTRIES - 1) * 7));
    add_op(CMD_FIND, 1'b0, rand_key(), rand_key(), bl + FIELD_W'(500));
    add_op(CMD_FIND, 1'b1, rand_key(), rand_key(), br + FIELD_W'(5000));
  endtask

  // Inserts and finds over small key pools so duplicates and hits are common.
  task automatic gen_pool_episode();
    logic [FIELD_W-1:0] bl;
    logic [FIELD_W-1:0] br;
    int pool;
    int n;
    int i;
    int r;
    bl   = rand_key();
    br   = rand_key();
    pool = $urandom_range(2, 40);
    n    = $urandom_range(8, 40);
    if ($urandom_range(0, 9) < 7) begin
      add_op(CMD_CLEAR, 1'($urandom_range(0, 1)), rand_key(), rand_key(), rand_key());
    end
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_op(CMD_INSERT, 1'($urandom_range(0, 1)),
               bl + FIELD_W'($urandom_range(0, pool - 1)),
               br + FIELD_W'($urandom_range(0, pool - 1)), rand_key());
      end else if (r < 80) begin
        add_op(CMD_FIND, 1'b0, rand_key(), rand_key(),
               bl + FIELD_W'($urandom_range(0, pool)));
      end else if (r < 95) begin
        add_op(CMD_FIND, 1'b1, rand_key(), rand_key(),
               br + FIELD_W'($urandom_range(0, pool)));
      end else begin
        add_op(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_key(),
               rand_key(), rand_key());
      end
    end
  endtask

  // Fully random items, the unused command among them.
  task automatic gen_noise_episode();
    int n;
    int i;
    n = $urandom_range(5, 15);
    for (i = 0; i < n; i++) begin
      add_op(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_key(),
             rand_key(), rand_key());
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int episode;
    int r;
    // Directed: empty table, key extremes, duplicate precedence, stale data.
    add_op(CMD_FIND, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
    add_op(CMD_INSERT, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    add_op(CMD_INSERT, 1'b0, 16'h0000, 16'h1234, 16'h0000);
    add_op(CMD_INSERT, 1'b0, 16'h5555, 16'hFFFF, 16'h0000);
    add_op(CMD_INSERT, 1'b0, 16'hAAAA, 16'h5555, 16'h0000);
    // Left matches a later pair, right matches an earlier one: right wins.
    add_op(CMD_INSERT, 1'b0, 16'hAAAA, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 1'b1, 16'hFFFF, 16'h5555, 16'h0000);
    add_op(CMD_FIND, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
    add_op(CMD_FIND, 1'b1, 16'h0000, 16'h0000, 16'h5555);
    add_op(CMD_FIND, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
    add_op(CMD_FIND, 1'b1, 16'h0000, 16'h0000, 16'h1234);
    add_op(CMD_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_op(CMD_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_op(CMD_FIND, 1'b0, 16'h0000, 16'h0000, 16'hAAAA);
    add_op(CMD_FIND, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
    add_op(CMD_INSERT, 1'b0, 16'h1234, 16'h4321, 16'h0000);
    add_op(CMD_FIND, 1'b0, 16'h0000, 16'h0000, 16'h1234);
    add_op(CMD_UNUSED, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    add_op(CMD_CLEAR, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    add_op(CMD_CLEAR, 1'b0, 16'h0000, 16'h0000, 16'h0000);

    // Random episodes; the first fills the table after a full drain.
    episode = 0;
    while (pending_ops.size() < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      drain_next = (episode == 0) || ($urandom_range(0, 4) == 0);
      if (episode == 0 || r < 10) begin
        gen_fill_episode();
      end else if (r < 80) begin
        gen_pool_episode();
      end else begin
        gen_noise_episode();
      end
      episode++;
    end
    ops_total = pending_ops.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_accepted < ops_total || awaited_replies.size() > 0) begin
      @(posedge clk);
    end
    // Any stray result in this window is flagged by the monitor.
    repeat (ENTRIES + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Driver: offers queued items, records each accepted one with the predictor.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(apply_to_table(offered_op));
        ops_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain || awaited_replies.size() == 0)) begin
          offered_op = pending_ops.pop_front();
          in_valid     <= 1'b1;
          in_cmd       <= offered_op.cmd;
          in_side      <= offered_op.side;
          in_key_left  <= offered_op.key_left;
          in_key_right <= offered_op.key_right;
          in_query_key <= offered_op.query_key;
          // Occasionally a stretch of back-to-back items.
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else if ($urandom_range(0, 49) == 0) begin
            send_burst = $urandom_range(20, 60);
            send_gap = 0;
          end else begin
            send_gap = pick_idle_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          $error("result with no item pending: status %0d found %0d partner %0h count %0d",
                 out_status, out_found, out_partner, out_entry_count);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            fail_count++;
          end
          if (out_partner !== want.partner) begin
            $error("partner: expected %0h, got %0h", want.partner, out_partner);
            fail_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_entry_count);
            fail_count++;
          end
        end
      end
      // One long hold while the sender keeps offering, so the block backs up.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && replies_seen >= HOLD_AFTER && in_valid) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_stall <= 1'b1;
      end else if (recv_burst > 0) begin
        recv_burst--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        recv_burst = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end else begin
        recv_stall = pick_idle_len();
        out_stall <= (recv_stall > 0);
        if (recv_stall > 0) recv_stall--;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
